>>> hw/rtl/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

    // coefficient and fixed-point format
    localparam int COEF_WIDTH  = 16;
    localparam int FRAC_BITS   = 16;

    // port widths
    localparam int COEF_PORT_W = 16;
    localparam int STATUS_W    = 2;
    localparam int DISC_OUT_W  = 34;
    localparam int ROOT_W      = 33;

    // internal widths derived from the format
    localparam int PROD_W      = 2 * COEF_WIDTH;
    localparam int DISC_W      = 2 * COEF_WIDTH + 2;
    localparam int RAD_BITS    = DISC_W - 1 + 2 * FRAC_BITS;
    localparam int RAD_W       = 2 * ((RAD_BITS + 1) / 2);
    localparam int SQ_W        = RAD_W / 2;
    localparam int SQ_REM_W    = SQ_W + 2;
    localparam int NB_W        = COEF_WIDTH + 1 + FRAC_BITS;
    localparam int NUM_W       = ((NB_W > SQ_W + 1) ? NB_W : SQ_W + 1) + 1;
    localparam int QUO_W       = NUM_W - 1;
    localparam int DEN_W       = COEF_WIDTH + 1;

    // queue depths, powers of two
    localparam int MID_DEPTH   = 4;
    localparam int MID_AW      = $clog2(MID_DEPTH);
    localparam int OUT_DEPTH   = 2;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);

    // root status codes
    localparam logic [STATUS_W-1:0] ST_TWO     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DOUBLE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COMPLEX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_LEAD = 2'd3;

    // classified item between front and back
    typedef struct packed {
        logic [STATUS_W-1:0]          status;
        logic signed [DISC_W-1:0]     disc;
        logic signed [COEF_WIDTH-1:0] coef_a;
        logic signed [COEF_WIDTH-1:0] coef_b;
    } t_mid;

    // mid queue status toward the control logic
    typedef struct packed {
        logic valid;
        logic full;
    } t_mid_stat;

    // finished result
    typedef struct packed {
        logic [STATUS_W-1:0]          status;
        logic signed [DISC_OUT_W-1:0] disc;
        logic signed [ROOT_W-1:0]     root_low;
        logic signed [ROOT_W-1:0]     root_high;
    } t_res;

endpackage

`default_nettype wire

>>> hw/rtl/qrs_front.sv
`default_nettype none

module qrs_front (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_en,
    input  wire logic                                   i_push,
    input  wire logic signed [qrs_pkg::COEF_PORT_W-1:0] i_coef_a,
    input  wire logic signed [qrs_pkg::COEF_PORT_W-1:0] i_coef_b,
    input  wire logic signed [qrs_pkg::COEF_PORT_W-1:0] i_coef_c,
    output logic                                        o_valid,
    output qrs_pkg::t_mid                               o_item
);

    localparam int CW = qrs_pkg::COEF_WIDTH;
    localparam int PW = qrs_pkg::PROD_W;
    localparam int DW = qrs_pkg::DISC_W;

    // coefficients read in their low CW bits
    logic signed [CW-1:0] a_cw;
    logic signed [CW-1:0] b_cw;
    logic signed [CW-1:0] c_cw;

    assign a_cw = CW'($unsigned(i_coef_a));
    assign b_cw = CW'($unsigned(i_coef_b));
    assign c_cw = CW'($unsigned(i_coef_c));

    // stage 1: products
    logic                 r_s1_vld;
    logic signed [PW-1:0] r_bb;
    logic signed [PW-1:0] r_ac;
    logic signed [CW-1:0] r_s1_a;
    logic signed [CW-1:0] r_s1_b;

    // stage 2: discriminant and class
    logic                 r_s2_vld;
    qrs_pkg::t_mid        r_s2_item;
    qrs_pkg::t_mid        n_s2_item;
    logic signed [DW-1:0] disc;

    always_comb begin
        disc = DW'(r_bb) - (DW'(r_ac) <<< 2);
        n_s2_item.disc   = disc;
        n_s2_item.coef_a = r_s1_a;
        n_s2_item.coef_b = r_s1_b;
        if (r_s1_a == '0) begin
            n_s2_item.status = qrs_pkg::ST_NO_LEAD;
        end else if (disc[DW-1]) begin
            n_s2_item.status = qrs_pkg::ST_COMPLEX;
        end else if (disc == '0) begin
            n_s2_item.status = qrs_pkg::ST_DOUBLE;
        end else begin
            n_s2_item.status = qrs_pkg::ST_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_push;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bb      <= b_cw * b_cw;
            r_ac      <= a_cw * c_cw;
            r_s1_a    <= a_cw;
            r_s1_b    <= b_cw;
            r_s2_item <= n_s2_item;
        end
    end

    assign o_valid = r_s2_vld;
    assign o_item  = r_s2_item;

endmodule

`default_nettype wire

>>> hw/rtl/qrs_mid_queue.sv
`default_nettype none

module qrs_mid_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire qrs_pkg::t_mid i_item,
    input  wire logic          i_pop,
    output qrs_pkg::t_mid      o_item,
    output qrs_pkg::t_mid_stat o_stat
);

    localparam int DEPTH = qrs_pkg::MID_DEPTH;
    localparam int AW    = qrs_pkg::MID_AW;

    qrs_pkg::t_mid r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rp];
    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.full  = (r_cnt == (AW+1)'(DEPTH));

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("mid queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_stat.valid)
        else $error("mid queue read while empty");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/qrs_sqrt.sv
`default_nettype none

module qrs_sqrt (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire qrs_pkg::t_mid            i_item,
    output logic                          o_valid,
    output qrs_pkg::t_mid                 o_item,
    output logic [qrs_pkg::SQ_W-1:0]      o_root
);

    localparam int DW    = qrs_pkg::DISC_W;
    localparam int RW    = qrs_pkg::RAD_W;
    localparam int SW    = qrs_pkg::SQ_W;
    localparam int REMW  = qrs_pkg::SQ_REM_W;
    localparam int FRAC2 = 2 * qrs_pkg::FRAC_BITS;

    // radicand: d scaled by 2^(2*frac), zero when d is negative
    logic [DW-2:0] d_mag;
    logic [RW-1:0] rad0;

    assign d_mag = i_item.disc[DW-1] ? '0 : i_item.disc[DW-2:0];
    assign rad0  = RW'(d_mag) << FRAC2;

    // one result bit per stage
    logic [SW-1:0]   r_vld;
    logic [RW-1:0]   r_rad  [SW];
    logic [REMW-1:0] r_rem  [SW];
    logic [SW-1:0]   r_root [SW];
    qrs_pkg::t_mid   r_item [SW];

    logic [RW-1:0]   n_rad  [SW];
    logic [REMW-1:0] n_rem  [SW];
    logic [SW-1:0]   n_root [SW];

    always_comb begin
        logic [RW-1:0]   rad_in;
        logic [REMW-1:0] rem_in;
        logic [SW-1:0]   root_in;
        logic [REMW-1:0] rem_t;
        logic [REMW-1:0] trial;
        logic            ge;
        for (int k = 0; k < SW; k++) begin
            if (k == 0) begin
                rad_in  = rad0;
                rem_in  = '0;
                root_in = '0;
            end else begin
                rad_in  = r_rad[k-1];
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
            end
            rem_t     = {rem_in[REMW-3:0], rad_in[RW-1 -: 2]};
            trial     = {root_in, 2'b01};
            ge        = (rem_t >= trial);
            n_rem[k]  = ge ? (rem_t - trial) : rem_t;
            n_root[k] = {root_in[SW-2:0], ge};
            n_rad[k]  = rad_in << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SW; k++) begin
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                if (k == 0) begin
                    r_item[k] <= i_item;
                end else begin
                    r_item[k] <= r_item[k-1];
                end
            end
        end
    end

    assign o_valid = r_vld[SW-1];
    assign o_item  = r_item[SW-1];
    assign o_root  = r_root[SW-1];

endmodule

`default_nettype wire

>>> hw/rtl/qrs_div.sv
`default_nettype none

module qrs_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire qrs_pkg::t_mid            i_item,
    input  wire logic [qrs_pkg::SQ_W-1:0] i_root,
    output logic                          o_valid,
    output qrs_pkg::t_res                 o_res
);

    localparam int CW   = qrs_pkg::COEF_WIDTH;
    localparam int FB   = qrs_pkg::FRAC_BITS;
    localparam int NW   = qrs_pkg::NUM_W;
    localparam int QW   = qrs_pkg::QUO_W;
    localparam int DNW  = qrs_pkg::DEN_W;
    localparam int RTW  = qrs_pkg::ROOT_W;
    localparam int DOW  = qrs_pkg::DISC_OUT_W;
    localparam int NSTG = QW + 3;

    // valid chain: numerators, magnitudes, QW divide steps, sign fix-up
    logic [NSTG-1:0] r_vld;

    // numerators -b*2^frac -/+ s and the divisor magnitude 2|a|
    logic signed [NW-1:0] b_ext;
    logic signed [NW-1:0] nb;
    logic signed [NW-1:0] s_ext;
    logic [CW-1:0]        a_mag;

    assign b_ext = NW'(i_item.coef_b);
    assign nb    = (NW'(0) - b_ext) <<< FB;
    assign s_ext = NW'(i_root);
    assign a_mag = i_item.coef_a[CW-1] ? $unsigned(-i_item.coef_a)
                                       : $unsigned(i_item.coef_a);

    qrs_pkg::t_mid        r_p1_item;
    logic signed [NW-1:0] r_p1_lo;
    logic signed [NW-1:0] r_p1_hi;
    logic [DNW-1:0]       r_p1_den;
    logic                 r_p1_aneg;

    // sign-magnitude split
    qrs_pkg::t_mid        r_p2_item;
    logic [QW-1:0]        r_p2_lo;
    logic [QW-1:0]        r_p2_hi;
    logic                 r_p2_neg_lo;
    logic                 r_p2_neg_hi;
    logic [DNW-1:0]       r_p2_den;

    logic [NW-1:0]        lo_abs;
    logic [NW-1:0]        hi_abs;

    assign lo_abs = r_p1_lo[NW-1] ? $unsigned(-r_p1_lo) : $unsigned(r_p1_lo);
    assign hi_abs = r_p1_hi[NW-1] ? $unsigned(-r_p1_hi) : $unsigned(r_p1_hi);

    // restoring divide, one quotient bit per stage, both roots side by side;
    // the numerator register fills with quotient bits as it shifts
    logic [QW-1:0]  r_dv_lo     [QW];
    logic [QW-1:0]  r_dv_hi     [QW];
    logic [DNW-1:0] r_dv_rem_lo [QW];
    logic [DNW-1:0] r_dv_rem_hi [QW];
    logic [DNW-1:0] r_dv_den    [QW];
    logic           r_dv_neg_lo [QW];
    logic           r_dv_neg_hi [QW];
    qrs_pkg::t_mid  r_dv_item   [QW];

    logic [QW-1:0]  n_dv_lo     [QW];
    logic [QW-1:0]  n_dv_hi     [QW];
    logic [DNW-1:0] n_dv_rem_lo [QW];
    logic [DNW-1:0] n_dv_rem_hi [QW];

    always_comb begin
        logic [QW-1:0]  lo_in;
        logic [QW-1:0]  hi_in;
        logic [DNW-1:0] rlo_in;
        logic [DNW-1:0] rhi_in;
        logic [DNW-1:0] den_in;
        logic [DNW:0]   t_lo;
        logic [DNW:0]   t_hi;
        logic [DNW:0]   d_lo;
        logic [DNW:0]   d_hi;
        logic           ge_lo;
        logic           ge_hi;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                lo_in  = r_p2_lo;
                hi_in  = r_p2_hi;
                rlo_in = '0;
                rhi_in = '0;
                den_in = r_p2_den;
            end else begin
                lo_in  = r_dv_lo[k-1];
                hi_in  = r_dv_hi[k-1];
                rlo_in = r_dv_rem_lo[k-1];
                rhi_in = r_dv_rem_hi[k-1];
                den_in = r_dv_den[k-1];
            end
            t_lo  = {rlo_in, lo_in[QW-1]};
            t_hi  = {rhi_in, hi_in[QW-1]};
            d_lo  = t_lo - {1'b0, den_in};
            d_hi  = t_hi - {1'b0, den_in};
            ge_lo = (t_lo >= {1'b0, den_in});
            ge_hi = (t_hi >= {1'b0, den_in});
            n_dv_rem_lo[k] = ge_lo ? d_lo[DNW-1:0] : t_lo[DNW-1:0];
            n_dv_rem_hi[k] = ge_hi ? d_hi[DNW-1:0] : t_hi[DNW-1:0];
            n_dv_lo[k]     = {lo_in[QW-2:0], ge_lo};
            n_dv_hi[k]     = {hi_in[QW-2:0], ge_hi};
        end
    end

    // sign fix-up, toward-zero quotient; zero roots unless real roots exist
    qrs_pkg::t_res        r_fin;
    qrs_pkg::t_res        n_fin;
    logic signed [QW:0]   q_lo;
    logic signed [QW:0]   q_hi;
    logic                 no_roots;

    always_comb begin
        q_lo = $signed({1'b0, r_dv_lo[QW-1]});
        q_hi = $signed({1'b0, r_dv_hi[QW-1]});
        if (r_dv_neg_lo[QW-1]) begin
            q_lo = -q_lo;
        end
        if (r_dv_neg_hi[QW-1]) begin
            q_hi = -q_hi;
        end
        no_roots = (r_dv_item[QW-1].status == qrs_pkg::ST_COMPLEX) ||
                   (r_dv_item[QW-1].status == qrs_pkg::ST_NO_LEAD);
        n_fin.status    = r_dv_item[QW-1].status;
        n_fin.disc      = DOW'(r_dv_item[QW-1].disc);
        n_fin.root_low  = no_roots ? '0 : RTW'(q_lo);
        n_fin.root_high = no_roots ? '0 : RTW'(q_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_item   <= i_item;
            r_p1_lo     <= nb - s_ext;
            r_p1_hi     <= nb + s_ext;
            r_p1_den    <= {a_mag, 1'b0};
            r_p1_aneg   <= i_item.coef_a[CW-1];

            r_p2_item   <= r_p1_item;
            r_p2_lo     <= lo_abs[QW-1:0];
            r_p2_hi     <= hi_abs[QW-1:0];
            r_p2_neg_lo <= r_p1_lo[NW-1] ^ r_p1_aneg;
            r_p2_neg_hi <= r_p1_hi[NW-1] ^ r_p1_aneg;
            r_p2_den    <= r_p1_den;

            for (int k = 0; k < QW; k++) begin
                r_dv_lo[k]     <= n_dv_lo[k];
                r_dv_hi[k]     <= n_dv_hi[k];
                r_dv_rem_lo[k] <= n_dv_rem_lo[k];
                r_dv_rem_hi[k] <= n_dv_rem_hi[k];
                if (k == 0) begin
                    r_dv_den[k]    <= r_p2_den;
                    r_dv_neg_lo[k] <= r_p2_neg_lo;
                    r_dv_neg_hi[k] <= r_p2_neg_hi;
                    r_dv_item[k]   <= r_p2_item;
                end else begin
                    r_dv_den[k]    <= r_dv_den[k-1];
                    r_dv_neg_lo[k] <= r_dv_neg_lo[k-1];
                    r_dv_neg_hi[k] <= r_dv_neg_hi[k-1];
                    r_dv_item[k]   <= r_dv_item[k-1];
                end
            end

            r_fin <= n_fin;
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_res   = r_fin;

endmodule

`default_nettype wire

>>> hw/rtl/quadratic_root_solver_top.sv
`default_nettype none

// channel   direction  handshake          payload
// -------   ---------  -----------------  ------------------------------------------
// input     in         push / full        i_coef_a, i_coef_b, i_coef_c (s16 each)
// result    out        empty / pop        o_root_status (2), o_discriminant (s34),
//                                         o_root_low (s33), o_root_high (s33)
//
// one item per cycle sustained unless a full queue stalls it; every item runs the same fixed pipeline
// from accept to the result ports an item passes the front, the mid queue, the
// one-bit-per-stage square root and divider chains and the result queue
// reset: synchronous, active low; clears valids, queue pointers and counts only
// full rises only when the 4-entry mid queue is full; the back end stalls as a
// whole when the 2-entry result queue is full, and the front keeps filling the mid queue

module quadratic_root_solver_top (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,

    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic signed [qrs_pkg::COEF_PORT_W-1:0] i_coef_a,
    input  wire logic signed [qrs_pkg::COEF_PORT_W-1:0] i_coef_b,
    input  wire logic signed [qrs_pkg::COEF_PORT_W-1:0] i_coef_c,

    output logic                                        empty,
    input  wire logic                                   pop,
    output logic [qrs_pkg::STATUS_W-1:0]                o_root_status,
    output logic signed [qrs_pkg::DISC_OUT_W-1:0]       o_discriminant,
    output logic signed [qrs_pkg::ROOT_W-1:0]           o_root_low,
    output logic signed [qrs_pkg::ROOT_W-1:0]           o_root_high
);

    localparam int OUT_DEPTH = qrs_pkg::OUT_DEPTH;
    localparam int OUT_AW    = qrs_pkg::OUT_AW;

    // front: products, discriminant, classification
    logic               en_front;
    logic               front_vld;
    qrs_pkg::t_mid      front_item;

    // mid queue decouples front and back
    qrs_pkg::t_mid      mid_item;
    qrs_pkg::t_mid_stat mid_stat;
    logic               mid_push;
    logic               mid_pop;

    // back: square root then divide, advancing together
    logic               en_back;
    logic               sq_vld;
    qrs_pkg::t_mid      sq_item;
    logic [qrs_pkg::SQ_W-1:0] sq_root;
    logic               dv_vld;
    qrs_pkg::t_res      dv_res;

    // result queue
    qrs_pkg::t_res      r_oq [OUT_DEPTH];
    logic [OUT_AW-1:0]  r_oq_wp;
    logic [OUT_AW-1:0]  r_oq_rp;
    logic [OUT_AW:0]    r_oq_cnt;
    logic               oq_push;
    logic               oq_pop;

    // the front stalls only on a full mid queue; the item in its last stage
    // moves into the queue whenever the front advances
    assign en_front = !mid_stat.full;
    assign full     = mid_stat.full;
    assign mid_push = en_front && front_vld;

    // the back end advances while the result queue has a free entry, which
    // also leaves room for the item in its last stage
    assign en_back  = (r_oq_cnt != (OUT_AW+1)'(OUT_DEPTH));
    assign mid_pop  = en_back && mid_stat.valid;
    assign oq_push  = en_back && dv_vld;
    assign oq_pop   = pop && !empty;

    qrs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en_front),
        .i_push   (push),
        .i_coef_a (i_coef_a),
        .i_coef_b (i_coef_b),
        .i_coef_c (i_coef_c),
        .o_valid  (front_vld),
        .o_item   (front_item)
    );

    qrs_mid_queue u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_item  (front_item),
        .i_pop   (mid_pop),
        .o_item  (mid_item),
        .o_stat  (mid_stat)
    );

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_back),
        .i_valid (mid_stat.valid),
        .i_item  (mid_item),
        .o_valid (sq_vld),
        .o_item  (sq_item),
        .o_root  (sq_root)
    );

    qrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_back),
        .i_valid (sq_vld),
        .i_item  (sq_item),
        .i_root  (sq_root),
        .o_valid (dv_vld),
        .o_res   (dv_res)
    );

    // result queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wp <= r_oq_wp + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rp <= r_oq_rp + 1'b1;
            end
            if (oq_push && !oq_pop) begin
                r_oq_cnt <= r_oq_cnt + 1'b1;
            end else if (!oq_push && oq_pop) begin
                r_oq_cnt <= r_oq_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wp] <= dv_res;
        end
    end

    // oldest result on the ports
    assign empty          = (r_oq_cnt == '0);
    assign o_root_status  = r_oq[r_oq_rp].status;
    assign o_discriminant = r_oq[r_oq_rp].disc;
    assign o_root_low     = r_oq[r_oq_rp].root_low;
    assign o_root_high    = r_oq[r_oq_rp].root_high;

`ifndef SYNTHESIS
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= (OUT_AW+1)'(OUT_DEPTH))
        else $error("result queue count beyond depth");

    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_root_status == qrs_pkg::ST_COMPLEX ||
                   o_root_status == qrs_pkg::ST_NO_LEAD)
        |-> o_root_low == '0 && o_root_high == '0)
        else $error("roots not cleared for an equation without real roots");

    a_double_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_root_status == qrs_pkg::ST_DOUBLE |-> o_root_low == o_root_high)
        else $error("double root halves differ");
`endif

endmodule

`default_nettype wire
